@@ sv/dst_pkg.sv @@
// Shared types and codes for the dequant slot tracker.
// Command, result status, slot state and config register encodings; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

  localparam int MASK_W = 32;

  typedef logic [1:0]        cmd_t;
  typedef logic [2:0]        res_t;
  typedef logic [1:0]        slot_state_t;
  typedef logic [MASK_W-1:0] rank_mask_t;

  localparam cmd_t CMD_PRIME    = 2'd0;
  localparam cmd_t CMD_SCHEDULE = 2'd1;
  localparam cmd_t CMD_ACQUIRE  = 2'd2;
  localparam cmd_t CMD_RELEASE  = 2'd3;

  localparam res_t RS_DONE   = 3'd0;
  localparam res_t RS_DIRECT = 3'd1;
  localparam res_t RS_SKIP   = 3'd2;
  localparam res_t RS_NOSLOT = 3'd3;
  localparam res_t RS_UNDER  = 3'd4;
  localparam res_t RS_IGN    = 3'd5;

  localparam slot_state_t SS_IDLE  = 2'd0;
  localparam slot_state_t SS_DEQ   = 2'd1;
  localparam slot_state_t SS_READY = 2'd2;

  // Config register indexes
  localparam logic CFG_NUM_RANKS    = 1'b0;
  localparam logic CFG_SLOTS_IN_USE = 1'b1;

  // Directory lookup outcome flags
  typedef struct packed {
    logic hit;
    logic vic_ok;
  } dir_flags_t;

endpackage

`default_nettype wire

@@ sv/dst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/dst_dir.sv @@
// Slot directory: per-slot tag and state, tag lookup and victim selection.
// Depends on dst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dst_dir #(
  parameter int SLOT_COUNT      = 8,
  parameter int PERMANENT_SLOTS = 2
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst,
  input  wire logic [6:0]                                       eff_slots,
  input  wire logic [7:0]                                       lk_layer,
  output dst_pkg::dir_flags_t                                   flags,
  output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0]  hit_slot,
  output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0]  vic_slot,
  input  wire logic                                             wr_en,
  input  wire logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] wr_slot,
  input  wire logic [7:0]                                       wr_tag,
  input  wire dst_pkg::slot_state_t                             wr_state
);
  import dst_pkg::*;

  localparam int SW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

  logic [7:0]  tag   [SLOT_COUNT];
  slot_state_t state [SLOT_COUNT];
  logic          idle_found;
  logic [SW-1:0] idle_slot;
  logic          rdy_found;
  logic [SW-1:0] rdy_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        state[s] <= SS_IDLE;
      end
    end else if (wr_en) begin
      state[wr_slot] <= wr_state;
    end
    if (wr_en) begin
      tag[wr_slot] <= wr_tag;
    end
  end

  // Scan downward so the lowest matching slot wins
  always_comb begin
    flags.hit  = 1'b0;
    hit_slot   = '0;
    idle_found = 1'b0;
    idle_slot  = '0;
    rdy_found  = 1'b0;
    rdy_slot   = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (7'(s) < eff_slots) begin
        if (tag[s] == lk_layer && state[s] != SS_IDLE) begin
          flags.hit = 1'b1;
          hit_slot  = SW'(s);
        end
        if (s >= PERMANENT_SLOTS && state[s] == SS_IDLE) begin
          idle_found = 1'b1;
          idle_slot  = SW'(s);
        end
        if (s >= PERMANENT_SLOTS && state[s] == SS_READY) begin
          rdy_found = 1'b1;
          rdy_slot  = SW'(s);
        end
      end
    end
    flags.vic_ok = idle_found | rdy_found;
    vic_slot     = idle_found ? idle_slot : rdy_slot;
  end

endmodule

`default_nettype wire

@@ sv/dequant_slot_tracker_top.sv @@
// Dequant slot tracker top level: command handshake, config registers,
// rank-mask RAM and commit logic. Depends on dst_pkg, dst_dir, dst_ram.
//
// Usage:
//   Requests (cmd, layer, rank, deq_needed) enter on in_valid/in_ready.
//   Each request yields exactly one result (status, slot_index,
//   launch_ranks, launch_async, wait_sync) on out_valid/out_ready.
//   In the accept cycle the slot directory is searched (tag match and
//   victim choice) and the launched/synced masks of the matching slot are
//   read from the mask RAM. In the next cycle the masks and slot state are
//   updated and the result is loaded into the output register.
//   out_valid rises with the commit; a request is not taken before the
//   previous one commits, set by the read-modify-write of the mask RAM
//   with its registered read data.
//   If the output register still holds an untaken result, the commit cycle
//   holds until it is taken; in_ready stays low meanwhile.
//   Reset marks every slot idle, clears the mask valid bits and sets
//   num_ranks to 1 and slots_in_use to 8; no clearing pass is needed.
//   Config writes (cfg_addr 0 num_ranks, 1 slots_in_use) apply at once;
//   the user must make them only while the block is idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module dequant_slot_tracker_top #(
  parameter int SLOT_COUNT      = 8,
  parameter int PERMANENT_SLOTS = 2,
  parameter int MAX_RANKS       = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [5:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  layer,
  input  wire logic [4:0]  rank,
  input  wire logic        deq_needed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [2:0]       slot_index,
  output logic [31:0]      launch_ranks,
  output logic             launch_async,
  output logic             wait_sync
);
  import dst_pkg::*;

  localparam int SW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic        fsm;
  logic [5:0]  num_ranks;
  logic [3:0]  slots_in_use;
  logic [5:0]  eff_ranks;
  logic [6:0]  eff_slots;
  rank_mask_t  all_mask;

  dir_flags_t    lk_flags;
  logic [SW-1:0] lk_hit_slot;
  logic [SW-1:0] lk_vic_slot;

  cmd_t          q_cmd;
  logic [7:0]    q_layer;
  logic [4:0]    q_rank;
  logic          q_deq;
  dir_flags_t    q_flags;
  logic [SW-1:0] q_hit_slot;
  logic [SW-1:0] q_vic_slot;
  logic          q_mask_ok;

  logic [SLOT_COUNT-1:0] mask_vld;
  logic [2*MASK_W-1:0]   ram_rdata;
  rank_mask_t            mem_l;
  rank_mask_t            mem_s;
  rank_mask_t            new_l;
  rank_mask_t            new_s;
  rank_mask_t            bit_m;

  logic        accept;
  logic        do_commit;
  res_t        res_status;
  logic [SW-1:0] res_slot;
  rank_mask_t  res_launch;
  logic        res_async;
  logic        res_wait;
  logic        dir_we;
  logic [SW-1:0] dir_slot;
  slot_state_t dir_state;
  logic        ram_we;
  logic [6:0]  slot_w;

  assign in_ready  = (fsm == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign do_commit = (fsm == ST_EXEC) & (~out_valid | out_ready);

  assign eff_ranks = (num_ranks < 6'(MAX_RANKS)) ? num_ranks : 6'(MAX_RANKS);
  assign eff_slots = ({3'b000, slots_in_use} < 7'(SLOT_COUNT)) ?
                     {3'b000, slots_in_use} : 7'(SLOT_COUNT);
  assign all_mask  = (eff_ranks >= 6'd32) ? '1 :
                     ((rank_mask_t'(1) << eff_ranks[4:0]) - rank_mask_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      num_ranks    <= 6'd1;
      slots_in_use <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_NUM_RANKS:    num_ranks    <= cfg_wdata;
        CFG_SLOTS_IN_USE: slots_in_use <= cfg_wdata[3:0];
        default:          num_ranks    <= num_ranks;
      endcase
    end
  end

  dst_dir #(
    .SLOT_COUNT     (SLOT_COUNT),
    .PERMANENT_SLOTS(PERMANENT_SLOTS)
  ) u_dir (
    .clk      (clk),
    .rst      (rst),
    .eff_slots(eff_slots),
    .lk_layer (layer),
    .flags    (lk_flags),
    .hit_slot (lk_hit_slot),
    .vic_slot (lk_vic_slot),
    .wr_en    (dir_we & do_commit),
    .wr_slot  (dir_slot),
    .wr_tag   (q_layer),
    .wr_state (dir_state)
  );

  dst_ram #(
    .WIDTH(2 * MASK_W),
    .DEPTH(SLOT_COUNT)
  ) u_mask_ram (
    .clk  (clk),
    .we   (ram_we & do_commit),
    .waddr(dir_slot),
    .wdata({new_l, new_s}),
    .re   (accept),
    .raddr(lk_hit_slot),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm      <= ST_IDLE;
      mask_vld <= '0;
    end else begin
      if (accept) begin
        fsm <= ST_EXEC;
      end else if (do_commit) begin
        fsm <= ST_IDLE;
      end
      if (ram_we && do_commit) begin
        mask_vld[dir_slot] <= 1'b1;
      end
    end
  end

  // Latch the request and the directory search
  always_ff @(posedge clk) begin
    if (accept) begin
      q_cmd      <= cmd;
      q_layer    <= layer;
      q_rank     <= rank;
      q_deq      <= deq_needed;
      q_flags    <= lk_flags;
      q_hit_slot <= lk_hit_slot;
      q_vic_slot <= lk_vic_slot;
      q_mask_ok  <= mask_vld[lk_hit_slot];
    end
  end

  // Masks never written read as zero
  assign mem_l = q_mask_ok ? ram_rdata[2*MASK_W-1:MASK_W] : '0;
  assign mem_s = q_mask_ok ? ram_rdata[MASK_W-1:0] : '0;
  assign bit_m = rank_mask_t'(1) << q_rank;

  always_comb begin
    res_status = RS_IGN;
    res_slot   = '0;
    res_launch = '0;
    res_async  = 1'b0;
    res_wait   = 1'b0;
    dir_we     = 1'b0;
    dir_slot   = q_hit_slot;
    dir_state  = SS_READY;
    ram_we     = 1'b0;
    new_l      = mem_l;
    new_s      = mem_s;
    unique case (q_cmd)
      CMD_PRIME: begin
        if (q_layer >= 8'(PERMANENT_SLOTS)) begin
          res_status = RS_IGN;
        end else if (q_layer >= {1'b0, eff_slots}) begin
          res_status = q_deq ? RS_UNDER : RS_IGN;
        end else begin
          res_slot  = SW'(q_layer);
          dir_slot  = SW'(q_layer);
          dir_we    = 1'b1;
          dir_state = SS_READY;
          if (!q_deq) begin
            res_status = RS_DIRECT;
          end else begin
            res_status = RS_DONE;
            res_launch = all_mask;
            ram_we     = 1'b1;
            new_l      = all_mask;
            new_s      = all_mask;
          end
        end
      end
      CMD_SCHEDULE: begin
        if (q_flags.hit) begin
          res_status = RS_SKIP;
          res_slot   = q_hit_slot;
        end else if (!q_deq) begin
          res_status = RS_DIRECT;
        end else if (!q_flags.vic_ok) begin
          res_status = RS_NOSLOT;
        end else begin
          res_status = RS_DONE;
          res_slot   = q_vic_slot;
          dir_slot   = q_vic_slot;
          dir_we     = 1'b1;
          dir_state  = SS_DEQ;
          ram_we     = 1'b1;
          new_l      = all_mask;
          new_s      = '0;
          res_launch = all_mask;
          res_async  = 1'b1;
        end
      end
      CMD_ACQUIRE: begin
        if (!q_deq) begin
          res_status = RS_DIRECT;
        end else if ({1'b0, q_rank} >= eff_ranks) begin
          res_status = RS_IGN;
        end else if (q_flags.hit) begin
          res_status = RS_DONE;
          res_slot   = q_hit_slot;
          dir_we     = 1'b1;
          ram_we     = 1'b1;
          if ((mem_l & bit_m) == '0) begin
            res_launch = bit_m;
            new_l      = mem_l | bit_m;
            new_s      = mem_s | bit_m;
          end else if ((mem_s & bit_m) == '0) begin
            res_wait = 1'b1;
            new_s    = mem_s | bit_m;
          end
          dir_state = (((new_l & all_mask) == all_mask) &&
                       ((new_s & all_mask) == all_mask)) ? SS_READY : SS_DEQ;
        end else if (!q_flags.vic_ok) begin
          res_status = RS_NOSLOT;
        end else begin
          res_status = RS_DONE;
          res_slot   = q_vic_slot;
          dir_slot   = q_vic_slot;
          dir_we     = 1'b1;
          ram_we     = 1'b1;
          res_launch = bit_m;
          new_l      = bit_m;
          new_s      = bit_m;
          dir_state  = (bit_m == all_mask) ? SS_READY : SS_DEQ;
        end
      end
      CMD_RELEASE: begin
        if (q_layer >= 8'(PERMANENT_SLOTS) && q_flags.hit) begin
          res_status = RS_DONE;
          res_slot   = q_hit_slot;
          dir_we     = 1'b1;
          dir_state  = SS_READY;
        end
      end
      default: begin
        res_status = RS_IGN;
      end
    endcase
  end

  assign slot_w = 7'(res_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_commit) begin
      status       <= res_status;
      slot_index   <= slot_w[2:0];
      launch_ranks <= res_launch;
      launch_async <= res_async;
      wait_sync    <= res_wait;
    end
  end

endmodule

`default_nettype wire

@@ sv/dst_chk.sv @@
// Port-level checker for the dequant slot tracker, bound to the top level.
// Depends on dst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dst_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic        launch_async,
  input wire logic        wait_sync
);
  import dst_pkg::*;

  // Result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped or changed while stalled");

  // One request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous still in flight");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("out_valid set right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= RS_IGN)
    else $error("undefined status code");

  // Only a fresh schedule launches asynchronously and never waits
  a_async_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (launch_async || wait_sync) |->
      status == RS_DONE && !(launch_async && wait_sync))
    else $error("async or wait flag on wrong result");

endmodule

bind dequant_slot_tracker_top dst_chk u_dst_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .launch_async(launch_async),
  .wait_sync   (wait_sync)
);

`default_nettype wire
